>>> rtl/spt_pkg.sv
// Shared types and constants for the spectral peak tracker.
`timescale 1ns / 1ps

package spt_pkg;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_DECAY_GAIN    = 2'd0;
    localparam t_reg_idx REG_HIT_INCREMENT = 2'd1;
    localparam t_reg_idx REG_CLAMP_BIN     = 2'd2;

    localparam logic [11:0] DECAY_GAIN_RST    = 12'd3686;
    localparam logic [15:0] HIT_INCREMENT_RST = 16'd5734;
    localparam logic [9:0]  CLAMP_BIN_RST     = 10'd734;

    localparam logic OP_BIN   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // floor(x / 30) == (x * 34953) >> 20 for every 16-bit x
    localparam logic [15:0] RECIP_30    = 16'd34953;
    localparam int          RECIP_SHIFT = 20;
    localparam int          GAIN_SHIFT  = 12;

endpackage

>>> rtl/spt_cnt_mem.sv
// Counter memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module spt_cnt_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/spectral_peak_tracker_core.sv
// Spectral peak tracker: per-bin leaky counters with frame and interval argmax.
// A bin without last flag reads, decays and writes back its counter; a last bin adds
//   the hit increment and an argmax walk over the counter memory.
// A query converts its hertz bounds to bins, then walks the argmax over that bin range.
// Throughput is one item at a time, bounded by the single memory read port and the
//   one shared multiplier; a finished result waits in the output register.
// Reset is synchronous; afterwards a clearing pass zeroes the counters.
`timescale 1ns / 1ps

module spectral_peak_tracker_core
    import spt_pkg::*;
#(
    parameter int NUM_BINS     = 1024,
    parameter int COUNTER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // bin / query input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [15:0] i_magnitude,
    input  logic        i_last_bin,
    input  logic [15:0] i_start_hz,
    input  logic [15:0] i_end_hz,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [9:0]  o_peak_bin,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int PW = $clog2(NUM_BINS + 1);
    localparam int CB = COUNTER_BITS;
    localparam int MW = (CB > 16) ? CB : 16;
    localparam int QW = 13;

    localparam logic [PW-1:0] NB_P      = PW'(NUM_BINS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);
    localparam logic [QW-1:0] LIM_MAX   = QW'(NUM_BINS - 1);
    localparam logic [MW:0]   CNT_MAX   = {(MW + 1 - CB)'(0), {CB{1'b1}}};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC_MUL,
        S_DEC_WR,
        S_HIT_RD,
        S_HIT_ADD,
        S_Q_START,
        S_Q_END,
        S_Q_RANGE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [11:0] r_gain;
    logic [15:0] r_inc;
    logic [9:0]  r_clamp;

    // frame tracking
    logic [PW-1:0] r_pos;
    logic [15:0]   r_fmax;
    logic [AW-1:0] r_fidx;
    logic          r_last;
    logic          r_kind;
    logic [15:0]   r_start_hz;
    logic [15:0]   r_end_hz;

    // clearing pass
    logic [AW-1:0] r_clr_addr;

    // shared multiplier
    logic [MW-1:0]    mul_a;
    logic [15:0]      mul_b;
    logic [MW+15:0]   mul_p;
    logic [MW+15:0]   r_prod;

    // argmax walk
    logic [PW-1:0] r_lo;
    logic [PW-1:0] r_hi;
    logic [PW-1:0] r_scan_addr;
    logic          r_first_issue;
    logic          r_take_first;
    logic          r_dvld;
    logic [AW-1:0] r_didx;
    logic [CB-1:0] r_best;
    logic [AW-1:0] r_best_idx;
    logic          scan_issue;

    // output register
    logic       r_ovalid;
    logic       r_okind;
    logic [9:0] r_opeak;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CB-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [CB-1:0] mem_rdata;

    logic          in_xfer;
    logic          cfg_wr;
    t_reg_idx      cfg_idx;
    logic [MW:0]   hit_sum;
    logic [CB-1:0] hit_val;
    logic [QW-1:0] limit;
    logic [QW-1:0] q_bin;
    logic [QW-1:0] q_s;
    logic [QW-1:0] q_s1;
    logic [QW-1:0] q_e;
    logic [AW+9:0] best_ext;

    spt_cnt_mem #(
        .DEPTH (NUM_BINS),
        .AW    (AW),
        .DW    (CB)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_xfer       = i_in_valid && o_in_ready;
    assign o_out_valid   = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_peak_bin    = r_opeak;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= DECAY_GAIN_RST;
            r_inc   <= HIT_INCREMENT_RST;
            r_clamp <= CLAMP_BIN_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DECAY_GAIN:    r_gain  <= pwdata[11:0];
                REG_HIT_INCREMENT: r_inc   <= pwdata[15:0];
                REG_CLAMP_BIN:     r_clamp <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DECAY_GAIN:    prdata = {20'd0, r_gain};
            REG_HIT_INCREMENT: prdata = {16'd0, r_inc};
            REG_CLAMP_BIN:     prdata = {22'd0, r_clamp};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        case (r_state)
            S_DEC_MUL: begin
                mul_a = MW'(mem_rdata);
                mul_b = {4'd0, r_gain};
            end
            S_Q_START: begin
                mul_a = MW'(r_start_hz);
                mul_b = RECIP_30;
            end
            default: begin
                mul_a = MW'(r_end_hz);
                mul_b = RECIP_30;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------- datapath helpers ----------------
    assign hit_sum = (MW + 1)'(mem_rdata) + (MW + 1)'(r_inc);
    assign hit_val = (hit_sum > CNT_MAX) ? {CB{1'b1}} : hit_sum[CB-1:0];

    assign limit = ({3'd0, r_clamp} > LIM_MAX) ? LIM_MAX : {3'd0, r_clamp};
    assign q_bin = QW'(r_prod >> RECIP_SHIFT);
    assign q_s1  = QW'(r_lo) + QW'(1);

    always_comb begin
        q_s = (q_bin > limit) ? limit : q_bin;
        q_e = (q_bin < q_s1) ? q_s1 : q_bin;
        if (q_e > limit) begin
            q_e = limit;
        end
    end

    assign scan_issue = r_first_issue || (r_scan_addr < r_hi);
    assign best_ext   = (AW + 10)'(r_best_idx);

    // ---------------- memory port control ----------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pos[AW-1:0];
        mem_wdata = CB'(r_prod >> GAIN_SHIFT);
        mem_raddr = r_pos[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_DEC_WR: begin
                mem_we = 1'b1;
            end
            S_HIT_RD: begin
                mem_raddr = r_fidx;
            end
            S_HIT_ADD: begin
                mem_we    = 1'b1;
                mem_waddr = r_fidx;
                mem_wdata = hit_val;
            end
            S_SCAN: begin
                mem_raddr = r_scan_addr[AW-1:0];
            end
            default: ;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_pos         <= '0;
            r_fmax        <= '0;
            r_fidx        <= '0;
            r_ovalid      <= 1'b0;
            r_dvld        <= 1'b0;
            r_first_issue <= 1'b0;
            r_take_first  <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_op == OP_QUERY) begin
                            r_state <= S_Q_START;
                        end else if (r_pos < NB_P) begin
                            if (i_magnitude > r_fmax) begin
                                r_fmax <= i_magnitude;
                                r_fidx <= r_pos[AW-1:0];
                            end
                            r_state <= S_DEC_MUL;
                        end else if (i_last_bin) begin
                            // past the last bin: only close the frame
                            r_state <= S_HIT_RD;
                        end
                    end
                end
                S_DEC_MUL: begin
                    r_state <= S_DEC_WR;
                end
                S_DEC_WR: begin
                    r_pos   <= r_pos + PW'(1);
                    r_state <= r_last ? S_HIT_RD : S_IDLE;
                end
                S_HIT_RD: begin
                    r_state <= S_HIT_ADD;
                end
                S_HIT_ADD: begin
                    r_pos         <= '0;
                    r_fmax        <= '0;
                    r_fidx        <= '0;
                    r_first_issue <= 1'b1;
                    r_take_first  <= 1'b1;
                    r_dvld        <= 1'b0;
                    r_state       <= S_SCAN;
                end
                S_Q_START: begin
                    r_state <= S_Q_END;
                end
                S_Q_END: begin
                    r_state <= S_Q_RANGE;
                end
                S_Q_RANGE: begin
                    r_first_issue <= 1'b1;
                    r_take_first  <= 1'b1;
                    r_dvld        <= 1'b0;
                    r_state       <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_dvld) begin
                        r_take_first <= 1'b0;
                    end
                    if (scan_issue) begin
                        r_dvld        <= 1'b1;
                        r_first_issue <= 1'b0;
                    end else begin
                        r_dvld <= 1'b0;
                        if (!r_dvld) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_out_ready) begin
                        r_okind <= r_kind;
                        r_opeak <= best_ext[9:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (in_xfer) begin
            r_last     <= i_last_bin;
            r_start_hz <= i_start_hz;
            r_end_hz   <= i_end_hz;
            r_kind     <= (i_op == OP_QUERY) ? KIND_QUERY : KIND_FRAME;
        end
        case (r_state)
            S_HIT_ADD: begin
                r_lo        <= '0;
                r_hi        <= NB_P;
                r_scan_addr <= '0;
            end
            S_Q_END: begin
                r_lo <= PW'(q_s);
            end
            S_Q_RANGE: begin
                r_hi        <= PW'(q_e);
                r_scan_addr <= r_lo;
            end
            S_SCAN: begin
                if (r_dvld && (r_take_first || mem_rdata > r_best)) begin
                    r_best     <= mem_rdata;
                    r_best_idx <= r_didx;
                end
                if (scan_issue) begin
                    r_didx      <= r_scan_addr[AW-1:0];
                    r_scan_addr <= r_scan_addr + PW'(1);
                end
            end
            default: ;
        endcase
    end

    // ---------------- assertions ----------------
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= NB_P)
        else $error("bin position beyond bin count");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_issue) |-> (r_scan_addr < NB_P))
        else $error("argmax walk reads past the counter memory");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the done state");

    a_no_write_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_SCAN) |-> !mem_we)
        else $error("counter write while idle or scanning");

endmodule

>>> dv/spt_peak_checker.sv
// Checker for the spectral peak tracker: channel monitor, peak predictor and scoreboard.
`timescale 1ns / 1ps

module spt_peak_checker
    import spt_pkg::*;
#(
    parameter int NUM_BINS     = 1024,
    parameter int COUNTER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_op,
    input  logic [15:0] i_magnitude,
    input  logic        i_last_bin,
    input  logic [15:0] i_start_hz,
    input  logic [15:0] i_end_hz,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_result_kind,
    input  logic [9:0]  i_peak_bin,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_frame_peaks,
    output int          o_query_answers
);

    localparam longint unsigned LEVEL_MAX = (64'd1 << COUNTER_BITS) - 64'd1;
    localparam int HZ_PER_BIN = 30;
    localparam int PRINT_CAP  = 100;

    typedef struct packed {
        logic       kind;
        logic [9:0] peak_bin;
    } peak_report_t;

    logic [COUNTER_BITS-1:0] bin_level [NUM_BINS];
    logic [11:0]             decay_gain;
    logic [15:0]             hit_inc;
    logic [9:0]              clamp_bin;
    int                      bin_pos;
    logic [15:0]             loud_mag;
    int                      loud_idx;
    peak_report_t            due_peaks [$];

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP)
            $display("%0t checker: %s", $time, msg);
        o_fail_count++;
    endtask

    // first index wins a tie; bin lo is always a candidate
    function automatic int strongest_bin(input int lo, input int hi);
        int best;
        best = lo;
        for (int i = lo + 1; i < hi && i < NUM_BINS; i++) begin
            if (bin_level[i] > bin_level[best])
                best = i;
        end
        return best;
    endfunction

    task automatic clear_tracker();
        for (int i = 0; i < NUM_BINS; i++)
            bin_level[i] = '0;
        decay_gain = DECAY_GAIN_RST;
        hit_inc    = HIT_INCREMENT_RST;
        clamp_bin  = CLAMP_BIN_RST;
        bin_pos    = 0;
        loud_mag   = '0;
        loud_idx   = 0;
        due_peaks.delete();
    endtask

    task automatic absorb_bin(input logic [15:0] mag, input logic last);
        logic [COUNTER_BITS+11:0] prod;
        longint unsigned          sum;
        peak_report_t             pk;
        // bins past the end of the counter array neither decay nor compete
        if (bin_pos < NUM_BINS) begin
            prod = bin_level[bin_pos] * decay_gain;
            bin_level[bin_pos] = prod[COUNTER_BITS+11:GAIN_SHIFT];
            if (mag > loud_mag) begin
                loud_mag = mag;
                loud_idx = bin_pos;
            end
            bin_pos++;
        end
        if (last) begin
            sum = bin_level[loud_idx];
            sum += hit_inc;
            if (sum > LEVEL_MAX)
                sum = LEVEL_MAX;
            bin_level[loud_idx] = COUNTER_BITS'(sum);
            pk.kind     = KIND_FRAME;
            pk.peak_bin = 10'(strongest_bin(0, NUM_BINS));
            due_peaks.push_back(pk);
            bin_pos  = 0;
            loud_mag = '0;
            loud_idx = 0;
        end
    endtask

    task automatic answer_query(input logic [15:0] shz, input logic [15:0] ehz);
        int           lim;
        int           lo;
        int           hi;
        peak_report_t pk;
        lim = (clamp_bin > NUM_BINS - 1) ? NUM_BINS - 1 : int'(clamp_bin);
        lo  = int'(shz) / HZ_PER_BIN;
        hi  = int'(ehz) / HZ_PER_BIN;
        if (lo > lim)
            lo = lim;
        if (hi < lo + 1)
            hi = lo + 1;
        if (hi > lim)
            hi = lim;
        pk.kind     = KIND_QUERY;
        pk.peak_bin = 10'(strongest_bin(lo, hi));
        due_peaks.push_back(pk);
    endtask

    always @(posedge i_clk) begin
        peak_report_t want;
        if (!i_rst_n) begin
            clear_tracker();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_peaks.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: kind %0d bin %0d",
                                              i_result_kind, i_peak_bin));
                end else begin
                    want = due_peaks.pop_front();
                    if (i_result_kind !== want.kind)
                        report_mismatch($sformatf("result_kind %0d, want %0d",
                                                  i_result_kind, want.kind));
                    if (i_peak_bin !== want.peak_bin)
                        report_mismatch($sformatf("peak_bin %0d, want %0d (kind %0d)",
                                                  i_peak_bin, want.peak_bin, want.kind));
                    if (want.kind == KIND_FRAME)
                        o_frame_peaks++;
                    else
                        o_query_answers++;
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_DECAY_GAIN:    decay_gain = i_pwdata[11:0];
                    REG_HIT_INCREMENT: hit_inc    = i_pwdata[15:0];
                    REG_CLAMP_BIN:     clamp_bin  = i_pwdata[9:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == OP_BIN)
                    absorb_bin(i_magnitude, i_last_bin);
                else
                    answer_query(i_start_hz, i_end_hz);
            end
        end
        o_pending = due_peaks.size();
    end

endmodule

>>> dv/tb_top.sv
// Testbench top for the spectral peak tracker: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
    import spt_pkg::*;

    localparam int NUM_BINS      = 1024;
    localparam int COUNTER_BITS  = 16;
    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int PHASE_ITEMS   = 130;
    localparam int OVERLONG_PASS = 4;
    localparam int IDLE_PCT      = 36;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LIMIT         = 10_000_000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_op        = OP_BIN;
    logic [15:0] i_magnitude = '0;
    logic        i_last_bin  = 1'b0;
    logic [15:0] i_start_hz  = '0;
    logic [15:0] i_end_hz    = '0;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_result_kind;
    logic [9:0]  o_peak_bin;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          n_frame_peaks;
    int          n_query_answers;
    int          n_items     = 0;
    int          n_settings  = 1;
    int          cycle_cnt   = 0;
    bit          no_idle     = 1'b0;
    bit          hold_off_req = 1'b0;
    logic [9:0]  cur_clamp   = CLAMP_BIN_RST;

    spectral_peak_tracker_core #(
        .NUM_BINS     (NUM_BINS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_magnitude   (i_magnitude),
        .i_last_bin    (i_last_bin),
        .i_start_hz    (i_start_hz),
        .i_end_hz      (i_end_hz),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_peak_bin    (o_peak_bin),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    spt_peak_checker #(
        .NUM_BINS     (NUM_BINS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_magnitude     (i_magnitude),
        .i_last_bin      (i_last_bin),
        .i_start_hz      (i_start_hz),
        .i_end_hz        (i_end_hz),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_result_kind   (o_result_kind),
        .i_peak_bin      (o_peak_bin),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_frame_peaks   (n_frame_peaks),
        .o_query_answers (n_query_answers)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // all stimulus tasks start and end on a falling edge
    task automatic send_item(input logic op, input logic [15:0] mag, input logic last,
                             input logic [15:0] shz, input logic [15:0] ehz);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_magnitude <= mag;
        i_last_bin  <= last;
        i_start_hz  <= shz;
        i_end_hz    <= ehz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic send_bin(input logic [15:0] mag, input logic last);
        send_item(OP_BIN, mag, last, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_query(input logic [15:0] shz, input logic [15:0] ehz);
        send_item(OP_QUERY, 16'($urandom), 1'($urandom), shz, ehz);
    endtask

    task automatic send_random_query();
        int lim;
        int r;
        int s_bin;
        int span;
        int ehz_full;
        logic [15:0] shz;
        logic [15:0] ehz;
        lim = (cur_clamp > NUM_BINS - 1) ? NUM_BINS - 1 : int'(cur_clamp);
        r   = $urandom_range(0, 99);
        if (r < 10) begin
            shz = 16'($urandom);
            ehz = 16'($urandom);
        end else begin
            s_bin    = $urandom_range(0, lim);
            span     = (r < 30) ? $urandom_range(0, lim) : $urandom_range(0, 16);
            shz      = 16'(s_bin * 30 + $urandom_range(0, 29));
            ehz_full = int'(shz) + span * 30 + $urandom_range(0, 29);
            ehz      = (ehz_full > 65535) ? 16'hFFFF : 16'(ehz_full);
            // reversed interval
            if (r >= 90)
                ehz = 16'($urandom_range(0, shz));
        end
        send_query(shz, ehz);
    endtask

    task automatic send_frame(input int len);
        int          style;
        logic [15:0] flat_mag;
        logic [15:0] mag;
        style    = $urandom_range(0, 99);
        flat_mag = 16'($urandom);
        for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 99) < 3)
                send_random_query();
            if (style < 60)
                mag = 16'($urandom);
            else if (style < 75)
                mag = flat_mag;
            else if (style < 90)
                mag = 16'($urandom_range(0, 15));
            else
                mag = '0;
            send_bin(mag, k == len - 1);
        end
    endtask

    // drop valid, wait for every pending result, then let the block settle
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [11:0] gain, input logic [15:0] inc,
                                 input logic [9:0] clamp);
        write_reg(REG_DECAY_GAIN, 32'(gain));
        write_reg(REG_HIT_INCREMENT, 32'(inc));
        write_reg(REG_CLAMP_BIN, 32'(clamp));
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_clamp  = clamp;
        n_settings++;
    endtask

    initial begin
        int          phase;
        int          phase_start;
        int          target;
        int          r;
        logic [11:0] gain;
        logic [15:0] inc;
        logic [9:0]  clamp;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty counters, range edges, ties, all-zero frame, mid-frame query
        send_query(16'd0, 16'd0);
        send_query(16'hFFFF, 16'd0);
        send_bin(16'hFFFF, 1'b1);
        send_bin(16'd7, 1'b0);
        send_bin(16'd9, 1'b0);
        send_bin(16'd9, 1'b0);
        send_query(16'd0, 16'hFFFF);
        send_bin(16'd3, 1'b1);
        send_bin(16'd0, 1'b0);
        send_bin(16'd0, 1'b1);
        send_query(16'd30, 16'd59);
        finish_phase();

        // widest settings: drive bin 0 into saturation, query the top bin
        load_settings(12'd4095, 16'hFFFF, 10'd1023);
        send_bin(16'h8000, 1'b1);
        send_bin(16'h8000, 1'b1);
        send_bin(16'h8000, 1'b1);
        send_query(16'hFFFF, 16'hFFFF);
        send_query(16'd0, 16'hFFFF);
        finish_phase();

        // narrowest settings: full decay, no increment, one-bin query limit
        load_settings(12'd0, 16'd0, 10'd1);
        send_bin(16'd5, 1'b0);
        send_bin(16'd0, 1'b1);
        send_query(16'hFFFF, 16'hFFFF);
        send_query(16'd0, 16'd0);
        send_query(16'd29, 16'd31);

        target = n_items + RANDOM_ITEMS;
        phase  = 0;
        while (n_items < target) begin
            finish_phase();
            if (phase == 0) begin
                load_settings(DECAY_GAIN_RST, HIT_INCREMENT_RST, CLAMP_BIN_RST);
            end else begin
                r     = $urandom_range(0, 99);
                gain  = (r < 15) ? 12'd4095 : (r < 20) ? 12'd0 : 12'($urandom_range(3000, 4095));
                r     = $urandom_range(0, 99);
                inc   = (r < 10) ? 16'hFFFF : (r < 15) ? 16'd0 : 16'($urandom);
                r     = $urandom_range(0, 99);
                clamp = (r < 10) ? 10'd1023 : (r < 20) ? 10'd1 : 10'($urandom_range(1, 1023));
                load_settings(gain, inc, clamp);
            end
            no_idle = (phase == 2);
            // let the block fill up behind a stalled result channel
            if (phase == 1)
                hold_off_req = 1'b1;
            // one frame runs past the end of the counter array
            if (phase == OVERLONG_PASS)
                send_frame(NUM_BINS + $urandom_range(1, 8));
            phase_start = n_items;
            while (n_items - phase_start < PHASE_ITEMS && n_items < target) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    send_random_query();
                else if (r < 38)
                    send_frame($urandom_range(64, 200));
                else
                    send_frame($urandom_range(1, 32));
            end
            phase++;
        end
        finish_phase();
        repeat (2 * NUM_BINS) @(negedge i_clk);

        $display("tb: %0d items over %0d register settings, %0d frame peaks and %0d interval answers",
                 n_items, n_settings, n_frame_peaks, n_query_answers);
        $display("tb: covered ties, saturation, clamp extremes, overlong frame, long output stall");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/spt_pkg.sv
rtl/spt_cnt_mem.sv
rtl/spectral_peak_tracker_core.sv
dv/spt_peak_checker.sv
dv/tb_top.sv
